/* rtl/gnsf_pkg.sv */
// Shared constants, types and reciprocal table for the grid smoothing filter.
// No dependencies; every other file uses this package.
package gnsf_pkg;

   localparam int SAMPLE_BITS = 16;
   localparam int MAX_WIDTH   = 32;
   localparam int MAX_HEIGHT  = 1024;
   localparam int MIN_DIM     = 2;

   localparam int COL_BITS    = $clog2(MAX_WIDTH);
   localparam int WIDTH_BITS  = $clog2(MAX_WIDTH + 1);
   localparam int ROW_BITS    = $clog2(MAX_HEIGHT);
   localparam int HEIGHT_BITS = $clog2(MAX_HEIGHT + 1);

   localparam int GRID_WIDTH_REG_BITS  = 6;
   localparam int GRID_HEIGHT_REG_BITS = 11;
   localparam int CSR_DATA_BITS        = 32;
   localparam int CSR_ADDR_BITS        = 3;
   localparam int REG_BYTE_SHIFT       = 2;
   localparam int REG_INDEX_BITS       = CSR_ADDR_BITS - REG_BYTE_SHIFT;

   localparam logic [REG_INDEX_BITS-1:0] REG_GRID_WIDTH  = REG_INDEX_BITS'(0);
   localparam logic [REG_INDEX_BITS-1:0] REG_GRID_HEIGHT = REG_INDEX_BITS'(1);

   localparam int WIN_TAPS   = 9;
   localparam int WIN_CENTER = 4;
   // sum of up to 8 neighbours plus 8 times the center
   localparam int NUM_BITS   = SAMPLE_BITS + 4;
   localparam int COUNT_BITS = 4;

   localparam logic [COUNT_BITS-1:0] CORNER_COUNT = COUNT_BITS'(3);
   localparam logic [COUNT_BITS-1:0] EDGE_COUNT   = COUNT_BITS'(5);
   localparam logic [COUNT_BITS-1:0] INNER_COUNT  = COUNT_BITS'(8);

   // floor(u / d) == (u * ceil(2^k / d)) >> k, exact for u < 2^(k-4)
   localparam int RECIP_SHIFT = SAMPLE_BITS + 7;
   localparam int RECIP_BITS  = RECIP_SHIFT - 2;
   localparam int MAG_BITS    = NUM_BITS - 1;
   localparam int PROD_BITS   = MAG_BITS + RECIP_BITS;

   localparam logic [RECIP_BITS-1:0] RECIP_6  =
      RECIP_BITS'(((64'd1 << RECIP_SHIFT) + 64'd5) / 64'd6);
   localparam logic [RECIP_BITS-1:0] RECIP_10 =
      RECIP_BITS'(((64'd1 << RECIP_SHIFT) + 64'd9) / 64'd10);
   localparam logic [RECIP_BITS-1:0] RECIP_16 =
      RECIP_BITS'((64'd1 << RECIP_SHIFT) / 64'd16);

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef sample_type [WIN_TAPS-1:0] window_type;

   typedef struct packed {
      logic [WIDTH_BITS-1:0]  width;
      logic [HEIGHT_BITS-1:0] height;
      logic                   restart;
   } grid_cfg_type;

   typedef struct packed {
      logic valid;
      logic top_ok;
      logic bot_ok;
      logic left_ok;
      logic right_ok;
      logic done;
   } win_meta_type;

   // reciprocal of twice the neighbour count
   function automatic logic [RECIP_BITS-1:0] recip_for(input logic [COUNT_BITS-1:0] cnt);
      logic [RECIP_BITS-1:0] m;
      case (cnt)
         CORNER_COUNT: m = RECIP_6;
         EDGE_COUNT:   m = RECIP_10;
         INNER_COUNT:  m = RECIP_16;
         default:      m = RECIP_16;
      endcase
      return m;
   endfunction

endpackage

/* rtl/gnsf_if.sv */
// Valid/ready channel interfaces for the sample stream and the smoothed stream.
// Depends on gnsf_pkg for the sample type.
interface gnsf_req_if;
   logic                 valid;
   logic                 ready;
   gnsf_pkg::sample_type height_in;

   modport source (output valid, output height_in, input ready);
   modport sink   (input valid, input height_in, output ready);
endinterface

interface gnsf_rsp_if;
   logic                 valid;
   logic                 ready;
   gnsf_pkg::sample_type height_out;
   logic                 grid_done;

   modport source (output valid, output height_out, output grid_done, input ready);
   modport sink   (input valid, input height_out, input grid_done, output ready);
endinterface

/* rtl/gnsf_csr.sv */
// APB register block: grid_width and grid_height, clamped for the datapath.
// Depends on gnsf_pkg.
module gnsf_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [gnsf_pkg::CSR_ADDR_BITS-1:0]   paddr,
   input  logic [gnsf_pkg::CSR_DATA_BITS-1:0]   pwdata,
   output logic [gnsf_pkg::CSR_DATA_BITS-1:0]   prdata,
   output logic                                 pready,
   output gnsf_pkg::grid_cfg_type               cfg
);
   import gnsf_pkg::*;

   logic [GRID_WIDTH_REG_BITS-1:0]  width_ff, width_in;
   logic [GRID_HEIGHT_REG_BITS-1:0] height_ff, height_in;
   logic [REG_INDEX_BITS-1:0]       reg_idx;
   logic                            wr;

   assign pready  = 1'b1;
   assign reg_idx = paddr[CSR_ADDR_BITS-1:REG_BYTE_SHIFT];
   assign wr      = psel && penable && pwrite && pready;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (wr) begin
         case (reg_idx)
            REG_GRID_WIDTH:  width_in  = pwdata[GRID_WIDTH_REG_BITS-1:0];
            REG_GRID_HEIGHT: height_in = pwdata[GRID_HEIGHT_REG_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= GRID_WIDTH_REG_BITS'(16);
         height_ff <= GRID_HEIGHT_REG_BITS'(16);
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   always_comb begin
      case (reg_idx)
         REG_GRID_WIDTH:  prdata = CSR_DATA_BITS'(width_ff);
         REG_GRID_HEIGHT: prdata = CSR_DATA_BITS'(height_ff);
         default:         prdata = '0;
      endcase
   end

   // out-of-range sizes clamp to the supported range
   always_comb begin
      if (width_ff < GRID_WIDTH_REG_BITS'(MIN_DIM))
         cfg.width = WIDTH_BITS'(MIN_DIM);
      else if (width_ff > GRID_WIDTH_REG_BITS'(MAX_WIDTH))
         cfg.width = WIDTH_BITS'(MAX_WIDTH);
      else
         cfg.width = WIDTH_BITS'(width_ff);

      if (height_ff < GRID_HEIGHT_REG_BITS'(MIN_DIM))
         cfg.height = HEIGHT_BITS'(MIN_DIM);
      else if (height_ff > GRID_HEIGHT_REG_BITS'(MAX_HEIGHT))
         cfg.height = HEIGHT_BITS'(MAX_HEIGHT);
      else
         cfg.height = HEIGHT_BITS'(height_ff);

      cfg.restart = wr;
   end

endmodule

/* rtl/gnsf_window.sv */
// Raster position tracking, end-of-grid flush sequencer, two line buffers
// and the 3x3 window with its boundary flags. Depends on gnsf_pkg, gnsf_if.
module gnsf_window (
   input  logic                    clock,
   input  logic                    reset,
   input  gnsf_pkg::grid_cfg_type  cfg,
   input  logic                    pipe_go,
   gnsf_req_if.sink                req,
   output gnsf_pkg::window_type    win,
   output gnsf_pkg::win_meta_type  meta,
   output logic                    flushing
);
   import gnsf_pkg::*;

   logic [COL_BITS-1:0]    col_ff, col_in;
   logic [ROW_BITS-1:0]    row_ff, row_in;
   logic                   flush_ff, flush_in;
   logic [WIDTH_BITS-1:0]  fcol_ff, fcol_in;
   sample_type             line_top [MAX_WIDTH];
   sample_type             line_mid [MAX_WIDTH];
   window_type             win_ff;
   win_meta_type           meta_ff;

   logic                   take, step, wrap, in_line, col0;
   logic                   last_row, last_col, has_result;
   logic [HEIGHT_BITS-1:0] pos_row, bot_row;
   logic [WIDTH_BITS-1:0]  pos_col;
   logic [COL_BITS-1:0]    addr;
   sample_type             x, top_new, mid_new, bot_new;

   assign req.ready = pipe_go && !flush_ff;
   assign take      = req.valid && req.ready;
   assign step      = take || (flush_ff && pipe_go);

   always_comb begin
      wrap = (HEIGHT_BITS'(row_ff) >= cfg.height) || (WIDTH_BITS'(col_ff) >= cfg.width);
      if (flush_ff) begin
         // flush positions sit one row below the grid
         pos_row = cfg.height;
         pos_col = fcol_ff;
         x       = '0;
      end else begin
         pos_row = wrap ? '0 : HEIGHT_BITS'(row_ff);
         pos_col = wrap ? '0 : WIDTH_BITS'(col_ff);
         x       = req.height_in;
      end
      in_line  = pos_col < cfg.width;
      addr     = pos_col[COL_BITS-1:0];
      col0     = pos_col == '0;
      top_new  = in_line ? line_top[addr] : '0;
      mid_new  = in_line ? line_mid[addr] : '0;
      bot_new  = in_line ? x : '0;
      last_row = pos_row == cfg.height - HEIGHT_BITS'(1);
      last_col = pos_col == cfg.width - WIDTH_BITS'(1);
      bot_row  = col0 ? pos_row - HEIGHT_BITS'(1) : pos_row;
      // at column 0 the center is the last column two rows up
      has_result = col0 ? (pos_row >= HEIGHT_BITS'(2)) : (pos_row >= HEIGHT_BITS'(1));
   end

   always_ff @(posedge clock) begin
      if (step && in_line) begin
         line_top[addr] <= line_mid[addr];
         line_mid[addr] <= x;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         for (int i = 0; i < 3; i++) begin
            win_ff[3*i]     <= win_ff[3*i + 1];
            win_ff[3*i + 1] <= win_ff[3*i + 2];
         end
         win_ff[2] <= top_new;
         win_ff[5] <= mid_new;
         win_ff[8] <= bot_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         meta_ff <= '0;
      end else if (pipe_go) begin
         meta_ff.valid    <= step && has_result;
         meta_ff.top_ok   <= col0 ? (pos_row >= HEIGHT_BITS'(3)) : (pos_row >= HEIGHT_BITS'(2));
         meta_ff.bot_ok   <= bot_row < cfg.height;
         meta_ff.left_ok  <= col0 || (pos_col >= WIDTH_BITS'(2));
         meta_ff.right_ok <= !col0 && in_line;
         meta_ff.done     <= flush_ff && (pos_col == cfg.width);
      end
   end

   always_comb begin
      col_in   = col_ff;
      row_in   = row_ff;
      flush_in = flush_ff;
      fcol_in  = fcol_ff;
      if (cfg.restart) begin
         col_in   = '0;
         row_in   = '0;
         flush_in = 1'b0;
      end else if (take) begin
         if (last_row && last_col) begin
            col_in   = '0;
            row_in   = '0;
            flush_in = 1'b1;
            fcol_in  = '0;
         end else if (last_col) begin
            col_in = '0;
            row_in = ROW_BITS'(pos_row + HEIGHT_BITS'(1));
         end else begin
            col_in = COL_BITS'(pos_col + WIDTH_BITS'(1));
            row_in = ROW_BITS'(pos_row);
         end
      end else if (flush_ff && pipe_go) begin
         if (fcol_ff == cfg.width)
            flush_in = 1'b0;
         else
            fcol_in = fcol_ff + WIDTH_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         row_ff   <= '0;
         flush_ff <= 1'b0;
         fcol_ff  <= '0;
      end else begin
         col_ff   <= col_in;
         row_ff   <= row_in;
         flush_ff <= flush_in;
         fcol_ff  <= fcol_in;
      end
   end

   assign win      = win_ff;
   assign meta     = meta_ff;
   assign flushing = flush_ff;

endmodule

/* rtl/gnsf_average.sv */
// Masked neighbour sum, then floor division by twice the count through a
// constant reciprocal; drives the result channel. Depends on gnsf_pkg, gnsf_if.
module gnsf_average (
   input  logic                    clock,
   input  logic                    reset,
   input  gnsf_pkg::window_type    win,
   input  gnsf_pkg::win_meta_type  meta,
   output logic                    pipe_go,
   gnsf_rsp_if.source              rsp
);
   import gnsf_pkg::*;

   logic [2:0]                   row_ok, col_ok;
   logic [WIN_TAPS-1:0]          mask;
   logic [COUNT_BITS-1:0]        n_cnt;
   logic signed [NUM_BITS-1:0]   sum, center_x, nc_prod, num_in;

   logic signed [NUM_BITS-1:0]   num_ff;
   logic [COUNT_BITS-1:0]        n_ff;
   logic                         valid2_ff, done2_ff;

   logic                         neg;
   logic [NUM_BITS-1:0]          mag_full;
   logic [MAG_BITS-1:0]          mag;
   logic [PROD_BITS-1:0]         prod;
   logic [SAMPLE_BITS-1:0]       quot;
   sample_type                   out_in;

   sample_type                   out_ff;
   logic                         valid3_ff, done3_ff;

   assign pipe_go = !valid3_ff || rsp.ready;

   // stage 2: masked sum plus n times the center
   always_comb begin
      row_ok = {meta.bot_ok, 1'b1, meta.top_ok};
      col_ok = {meta.right_ok, 1'b1, meta.left_ok};
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            mask[3*i + j] = row_ok[i] && col_ok[j] && ((3*i + j) != WIN_CENTER);
         end
      end
      n_cnt = COUNT_BITS'($countones(mask));
      sum   = '0;
      for (int k = 0; k < WIN_TAPS; k++) begin
         if (mask[k])
            sum = sum + NUM_BITS'($signed(win[k]));
      end
      center_x = NUM_BITS'($signed(win[WIN_CENTER]));
      nc_prod  = center_x * $signed({1'b0, n_cnt});
      num_in   = sum + nc_prod;
   end

   always_ff @(posedge clock) begin
      if (pipe_go) begin
         num_ff   <= num_in;
         n_ff     <= n_cnt;
         done2_ff <= meta.done;
      end
   end

   // stage 3: floor(num / 2n); negative values use floor((-1 - u)/d) = ~floor(~num/d)
   always_comb begin
      neg      = num_ff[NUM_BITS-1];
      mag_full = neg ? ~num_ff : num_ff;
      mag      = mag_full[MAG_BITS-1:0];
      prod     = PROD_BITS'(mag) * PROD_BITS'(recip_for(n_ff));
      quot     = prod[RECIP_SHIFT +: SAMPLE_BITS];
      out_in   = neg ? ~quot : quot;
   end

   always_ff @(posedge clock) begin
      if (pipe_go) begin
         out_ff   <= out_in;
         done3_ff <= done2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid2_ff <= 1'b0;
         valid3_ff <= 1'b0;
      end else if (pipe_go) begin
         valid2_ff <= meta.valid;
         valid3_ff <= valid2_ff;
      end
   end

   assign rsp.valid      = valid3_ff;
   assign rsp.height_out = out_ff;
   assign rsp.grid_done  = done3_ff;

endmodule

/* rtl/grid_neighbour_smoothing_filter.sv */
// Grid smoothing filter top: 3x3 neighbor average of a raster height grid.
// Uses gnsf_pkg, gnsf_if, gnsf_csr, gnsf_window, gnsf_average.
// Throughput: one word per cycle unless the result channel back-pressures; after the
// last word of a grid the input stalls while the flush steps drain the line buffers.
// A result passes the window, sum and output registers in turn, one row plus one
// word behind the input. Sync reset: control state, 16x16, empty pipe.
module grid_neighbour_smoothing_filter (
   input  logic                                clock,
   input  logic                                reset,
   gnsf_req_if.sink                            req_ch,
   gnsf_rsp_if.source                          rsp_ch,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [gnsf_pkg::CSR_ADDR_BITS-1:0]  paddr,
   input  logic [gnsf_pkg::CSR_DATA_BITS-1:0]  pwdata,
   output logic [gnsf_pkg::CSR_DATA_BITS-1:0]  prdata,
   output logic                                pready
);
   import gnsf_pkg::*;

   grid_cfg_type  cfg;
   window_type    win;
   win_meta_type  meta;
   logic          pipe_go;
   logic          flushing;

   // Register block. Any write restarts the grid at row 0, column 0;
   // the user must issue writes only while the filter is idle; the block does not enforce this.
   gnsf_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Stage 1: every accepted word (or flush step) shifts one column into the
   // window and updates the line buffers at its column. The flags registered
   // with it say which of the eight neighbors of the window center lie inside
   // the grid, so junk left in the line buffers or window never counts.
   gnsf_window u_window (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .pipe_go  (pipe_go),
      .req      (req_ch),
      .win      (win),
      .meta     (meta),
      .flushing (flushing)
   );

   // Stages 2 and 3: neighbor sum, then reciprocal multiply and output
   // register. The whole pipe advances together whenever the output register
   // is empty or being drained; a result stalled in the output register
   // freezes every stage and holds off the input.
   gnsf_average u_average (
      .clock   (clock),
      .reset   (reset),
      .win     (win),
      .meta    (meta),
      .pipe_go (pipe_go),
      .rsp     (rsp_ch)
   );

`ifndef SYNTHESIS
   // a stalled result freezes the pipe, so no word may enter
   assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.ready) |-> !req_ch.ready)
      else $error("input taken while the result register is stalled");

   // no word is taken while the flush steps are running
   assert property (@(posedge clock) disable iff (reset)
      flushing |-> !req_ch.ready)
      else $error("input taken during end-of-grid flush");

   // the last result of a grid leaves an empty pipe behind it
   assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.ready && rsp_ch.grid_done) |=> (!rsp_ch.valid && req_ch.ready))
      else $error("pipeline not drained after the last result of a grid");
`endif

endmodule
